### rtl/fca_pkg.sv
package fca_pkg;

  // Field widths of the item payloads
  localparam int unsigned FCA_MODE_W = 3;
  localparam int unsigned FCA_BLK_W  = 12;
  localparam int unsigned FCA_CNT_W  = 12;
  localparam int unsigned FCA_LINK_W = 16;
  localparam int unsigned FCA_ST_W   = 2;

  // Table geometry and link codes
  localparam int unsigned NUM_BLOCKS_DEF  = 4096;
  localparam int unsigned RESERVED_LAST   = 5;
  localparam logic [FCA_LINK_W-1:0] LINK_FREE = 16'h0000;
  localparam logic [FCA_LINK_W-1:0] LINK_END  = 16'hFFFF;
  localparam logic [FCA_BLK_W-1:0]  FIRST_ALLOC_RST = 12'd6;

  typedef enum logic [FCA_MODE_W-1:0] {
    MODE_ALLOC  = 3'd0,
    MODE_FREE   = 3'd1,
    MODE_WALK   = 3'd2,
    MODE_LAST   = 3'd3,
    MODE_EXTEND = 3'd4,
    MODE_READ   = 3'd5,
    MODE_WRITE  = 3'd6,
    MODE_FORMAT = 3'd7
  } mode_e;

  typedef enum logic [FCA_ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BROKEN  = 2'd2,
    ST_LIMIT   = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                 mode;
    logic [FCA_BLK_W-1:0]  block;
    logic [FCA_CNT_W-1:0]  count;
    logic [FCA_LINK_W-1:0] link_value;
  } fca_in_t;

  typedef struct packed {
    logic [FCA_LINK_W-1:0] result_block;
    status_e               status;
  } fca_out_t;

  // Datapath selects
  typedef enum logic [1:0] {
    WA_CUR   = 2'd0,
    WA_SCAN  = 2'd1,
    WA_SWEEP = 2'd2
  } waddr_sel_e;

  typedef enum logic [2:0] {
    WD_ZERO = 3'd0,
    WD_END  = 3'd1,
    WD_VAL  = 3'd2,
    WD_SCAN = 3'd3,
    WD_FMT  = 3'd4
  } wdata_sel_e;

  typedef enum logic {
    RA_CUR  = 1'b0,
    RA_SCAN = 1'b1
  } raddr_sel_e;

  typedef enum logic [2:0] {
    RS_ZERO  = 3'd0,
    RS_BLK   = 3'd1,
    RS_CUR   = 3'd2,
    RS_RDATA = 3'd3,
    RS_SCAN  = 3'd4,
    RS_VAL   = 3'd5
  } res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       mem_we;
    waddr_sel_e waddr_sel;
    wdata_sel_e wdata_sel;
    raddr_sel_e raddr_sel;
    logic       cur_adv;
    logic       scan_init;
    logic       scan_adv;
    logic       sweep_adv;
    logic       res_we;
    res_sel_e   res_sel;
    status_e    st_val;
    logic       out_load;
  } fca_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_e in_mode;
    logic  in_range;
    mode_e mode;
    logic  scan_end;
    logic  walk_done;
    logic  walk_lim;
    logic  v_zero;
    logic  v_end;
    logic  v_broken;
    logic  sweep_last;
    logic  out_free;
  } fca_stat_t;

endpackage

### rtl/fca_dp.sv
module fca_dp #(
  parameter int unsigned NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fca_pkg::fca_in_t               in_item_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output fca_pkg::fca_out_t              out_item_o,
  input  logic                           cfg_we_i,
  input  logic [fca_pkg::FCA_BLK_W-1:0]  cfg_wdata_i,
  input  fca_pkg::fca_cmd_t              cmd_i,
  output fca_pkg::fca_stat_t             stat_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned SCAN_W = (CNT_W > fca_pkg::FCA_BLK_W) ? CNT_W : fca_pkg::FCA_BLK_W;
  localparam int unsigned LW     = fca_pkg::FCA_LINK_W;

  logic [LW-1:0]                 mem [NUM_BLOCKS];
  logic [LW-1:0]                 rdata_q;
  logic [IDX_W-1:0]              raddr, waddr;
  logic [LW-1:0]                 wdata;

  logic [fca_pkg::FCA_BLK_W-1:0] first_q;
  logic [IDX_W-1:0]              sweep_q, sweep_d;
  logic                          out_valid_q;
  fca_pkg::fca_out_t             out_item_q;

  fca_pkg::mode_e                mode_q;
  logic [IDX_W-1:0]              cur_q;
  logic [CNT_W-1:0]              n_q;
  logic [fca_pkg::FCA_CNT_W-1:0] count_q;
  logic [LW-1:0]                 val_q;
  logic [SCAN_W-1:0]             scan_q;
  logic [LW-1:0]                 res_q, res_d;
  fca_pkg::status_e              st_q;
  logic                          sweep_last;

  // Table port selection
  always_comb begin
    case (cmd_i.raddr_sel)
      fca_pkg::RA_SCAN: raddr = IDX_W'(scan_q);
      default:          raddr = cur_q;
    endcase
    case (cmd_i.waddr_sel)
      fca_pkg::WA_SCAN:  waddr = IDX_W'(scan_q);
      fca_pkg::WA_SWEEP: waddr = sweep_q;
      default:           waddr = cur_q;
    endcase
    case (cmd_i.wdata_sel)
      fca_pkg::WD_END:  wdata = fca_pkg::LINK_END;
      fca_pkg::WD_VAL:  wdata = val_q;
      fca_pkg::WD_SCAN: wdata = LW'(scan_q);
      fca_pkg::WD_FMT:  wdata = (SCAN_W'(sweep_q) <= SCAN_W'(fca_pkg::RESERVED_LAST)) ?
                                fca_pkg::LINK_END : fca_pkg::LINK_FREE;
      default:          wdata = fca_pkg::LINK_FREE;
    endcase
  end

  // Link table: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Allocation start register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= fca_pkg::FIRST_ALLOC_RST;
    end else if (cfg_we_i) begin
      first_q <= cfg_wdata_i;
    end
  end

  // Sweep counter for clearing and format, wraps to zero at the end
  assign sweep_last = (sweep_q == IDX_W'(NUM_BLOCKS - 1));
  assign sweep_d    = sweep_last ? '0 : sweep_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_adv) begin
      sweep_q <= sweep_d;
    end
  end

  // Result selection
  always_comb begin
    case (cmd_i.res_sel)
      fca_pkg::RS_BLK:   res_d = LW'(in_item_i.block);
      fca_pkg::RS_CUR:   res_d = LW'(cur_q);
      fca_pkg::RS_RDATA: res_d = rdata_q;
      fca_pkg::RS_SCAN:  res_d = LW'(scan_q);
      fca_pkg::RS_VAL:   res_d = val_q;
      default:           res_d = '0;
    endcase
  end

  // Working registers of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_item_i.mode;
      cur_q   <= IDX_W'(in_item_i.block);
      n_q     <= '0;
      count_q <= in_item_i.count;
      val_q   <= in_item_i.link_value;
    end else if (cmd_i.cur_adv) begin
      cur_q <= IDX_W'(rdata_q);
      n_q   <= n_q + 1'b1;
    end
    if (cmd_i.scan_init) begin
      scan_q <= (first_q == '0) ? SCAN_W'(1) : SCAN_W'(first_q);
    end else if (cmd_i.scan_adv) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.res_we) begin
      res_q <= res_d;
      st_q  <= cmd_i.st_val;
    end
  end

  // Output register: holds the item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.result_block <= res_q;
      out_item_q.status       <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Status towards the controller
  always_comb begin
    stat_o.in_mode    = in_item_i.mode;
    stat_o.in_range   = SCAN_W'(in_item_i.block) < SCAN_W'(NUM_BLOCKS);
    stat_o.mode       = mode_q;
    stat_o.scan_end   = scan_q >= SCAN_W'(NUM_BLOCKS);
    stat_o.walk_done  = SCAN_W'(n_q) == SCAN_W'(count_q);
    stat_o.walk_lim   = n_q == CNT_W'(NUM_BLOCKS);
    stat_o.v_zero     = rdata_q == fca_pkg::LINK_FREE;
    stat_o.v_end      = rdata_q == fca_pkg::LINK_END;
    stat_o.v_broken   = (rdata_q == fca_pkg::LINK_FREE) ||
                        ((rdata_q != fca_pkg::LINK_END) &&
                         ({1'b0, rdata_q} >= (LW + 1)'(NUM_BLOCKS)));
    stat_o.sweep_last = sweep_last;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

### rtl/fca_ctrl.sv
module fca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fca_pkg::fca_stat_t stat_i,
  output fca_pkg::fca_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_WRD   = 10'b0000000100,
    S_WEV   = 10'b0000001000,
    S_SRD   = 10'b0000010000,
    S_SEV   = 10'b0000100000,
    S_LINK  = 10'b0001000000,
    S_ENTRY = 10'b0010000000,
    S_FMT   = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      // Clear the table after reset, one entry a cycle
      S_INIT: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.waddr_sel = fca_pkg::WA_SWEEP;
        cmd_o.wdata_sel = fca_pkg::WD_ZERO;
        cmd_o.sweep_adv = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      // Take an item and dispatch on its mode
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.in_mode == fca_pkg::MODE_ALLOC) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SRD;
          end else if (stat_i.in_mode == fca_pkg::MODE_FORMAT) begin
            state_d = S_FMT;
          end else if (!stat_i.in_range) begin
            cmd_o.res_we  = 1'b1;
            cmd_o.st_val  = fca_pkg::ST_BROKEN;
            cmd_o.res_sel = (stat_i.in_mode == fca_pkg::MODE_READ ||
                             stat_i.in_mode == fca_pkg::MODE_WRITE) ?
                            fca_pkg::RS_ZERO : fca_pkg::RS_BLK;
            state_d       = S_RESP;
          end else if (stat_i.in_mode == fca_pkg::MODE_WRITE) begin
            state_d = S_ENTRY;
          end else begin
            state_d = S_WRD;
          end
        end
      end
      // Check the step limits and read the current entry
      S_WRD: begin
        cmd_o.raddr_sel = fca_pkg::RA_CUR;
        cmd_o.res_sel   = (stat_i.mode == fca_pkg::MODE_FREE) ?
                          fca_pkg::RS_ZERO : fca_pkg::RS_CUR;
        if (stat_i.mode == fca_pkg::MODE_WALK && stat_i.walk_done) begin
          cmd_o.res_we = 1'b1;
          cmd_o.st_val = fca_pkg::ST_OK;
          state_d      = S_RESP;
        end else if (stat_i.mode != fca_pkg::MODE_READ && stat_i.walk_lim) begin
          cmd_o.res_we = 1'b1;
          cmd_o.st_val = fca_pkg::ST_LIMIT;
          state_d      = S_RESP;
        end else begin
          state_d = S_WEV;
        end
      end
      // Act on the link just read
      S_WEV: begin
        case (stat_i.mode)
          fca_pkg::MODE_READ: begin
            cmd_o.res_we  = 1'b1;
            cmd_o.res_sel = fca_pkg::RS_RDATA;
            cmd_o.st_val  = fca_pkg::ST_OK;
            state_d       = S_RESP;
          end
          fca_pkg::MODE_FREE: begin
            cmd_o.res_sel = fca_pkg::RS_ZERO;
            if (stat_i.v_zero) begin
              cmd_o.res_we = 1'b1;
              cmd_o.st_val = fca_pkg::ST_BROKEN;
              state_d      = S_RESP;
            end else begin
              // free this entry, then stop on an end mark or a bad link
              cmd_o.mem_we    = 1'b1;
              cmd_o.waddr_sel = fca_pkg::WA_CUR;
              cmd_o.wdata_sel = fca_pkg::WD_ZERO;
              if (stat_i.v_end) begin
                cmd_o.res_we = 1'b1;
                cmd_o.st_val = fca_pkg::ST_OK;
                state_d      = S_RESP;
              end else if (stat_i.v_broken) begin
                cmd_o.res_we = 1'b1;
                cmd_o.st_val = fca_pkg::ST_BROKEN;
                state_d      = S_RESP;
              end else begin
                cmd_o.cur_adv = 1'b1;
                state_d       = S_WRD;
              end
            end
          end
          fca_pkg::MODE_WALK: begin
            cmd_o.res_sel = fca_pkg::RS_CUR;
            if (stat_i.v_end || stat_i.v_broken) begin
              cmd_o.res_we = 1'b1;
              cmd_o.st_val = fca_pkg::ST_BROKEN;
              state_d      = S_RESP;
            end else begin
              cmd_o.cur_adv = 1'b1;
              state_d       = S_WRD;
            end
          end
          default: begin
            // find last, and the tail search of extend
            cmd_o.res_sel = fca_pkg::RS_CUR;
            if (stat_i.v_end) begin
              if (stat_i.mode == fca_pkg::MODE_EXTEND) begin
                cmd_o.scan_init = 1'b1;
                state_d         = S_SRD;
              end else begin
                cmd_o.res_we = 1'b1;
                cmd_o.st_val = fca_pkg::ST_OK;
                state_d      = S_RESP;
              end
            end else if (stat_i.v_broken) begin
              cmd_o.res_we = 1'b1;
              cmd_o.st_val = fca_pkg::ST_BROKEN;
              state_d      = S_RESP;
            end else begin
              cmd_o.cur_adv = 1'b1;
              state_d       = S_WRD;
            end
          end
        endcase
      end
      // Read the next candidate of the free scan
      S_SRD: begin
        cmd_o.raddr_sel = fca_pkg::RA_SCAN;
        if (stat_i.scan_end) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_sel = fca_pkg::RS_ZERO;
          cmd_o.st_val  = fca_pkg::ST_NO_FREE;
          state_d       = S_RESP;
        end else begin
          state_d = S_SEV;
        end
      end
      // Claim a free entry or advance the scan
      S_SEV: begin
        if (stat_i.v_zero) begin
          cmd_o.mem_we    = 1'b1;
          cmd_o.waddr_sel = fca_pkg::WA_SCAN;
          cmd_o.wdata_sel = fca_pkg::WD_END;
          cmd_o.res_we    = 1'b1;
          cmd_o.res_sel   = fca_pkg::RS_SCAN;
          cmd_o.st_val    = fca_pkg::ST_OK;
          state_d         = (stat_i.mode == fca_pkg::MODE_EXTEND) ? S_LINK : S_RESP;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SRD;
        end
      end
      // Link the old tail to the new block
      S_LINK: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.waddr_sel = fca_pkg::WA_CUR;
        cmd_o.wdata_sel = fca_pkg::WD_SCAN;
        state_d         = S_RESP;
      end
      S_ENTRY: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.waddr_sel = fca_pkg::WA_CUR;
        cmd_o.wdata_sel = fca_pkg::WD_VAL;
        cmd_o.res_we    = 1'b1;
        cmd_o.res_sel   = fca_pkg::RS_VAL;
        cmd_o.st_val    = fca_pkg::ST_OK;
        state_d         = S_RESP;
      end
      // Rewrite the whole table, reserved blocks as chain ends
      S_FMT: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.waddr_sel = fca_pkg::WA_SWEEP;
        cmd_o.wdata_sel = fca_pkg::WD_FMT;
        cmd_o.sweep_adv = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_sel = fca_pkg::RS_ZERO;
          cmd_o.st_val  = fca_pkg::ST_OK;
          state_d       = S_RESP;
        end
      end
      // Hand the result to the output register once it is free
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

### rtl/fat_chain_allocator_core.sv
// Allocation-table chain engine.
// Input channel in_valid_i / in_ready_o carries one operation item
// (mode, block, count, link_value); output channel out_valid_o /
// out_ready_i returns exactly one item (result_block, status) for each.
// cfg_we_i / cfg_wdata_i write the lowest allocatable block at any edge.
// One item is worked on at a time; the table is a single-port-write,
// registered-read memory and every visited entry takes an address
// state, then an evaluate state. Walk, find last, free chain and the
// tail search of extend follow the chain link by link; alloc and
// extend scan upward for a free entry; format rewrites every entry;
// read and write touch one entry; out-of-range items are answered
// without touching the table.
// The next item can be accepted in the cycle after the result is loaded.
// After reset the table is cleared, one entry at a time, with
// in_ready_o low; configuration writes are taken during that time.
// A finished result sits in the output register; while the receiver
// stalls, the next item may be accepted and worked on, but its result
// waits until the register has been emptied.
module fat_chain_allocator_core #(
  parameter int unsigned NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fca_pkg::fca_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fca_pkg::fca_out_t             out_item_o,
  input  logic                          cfg_we_i,
  input  logic [fca_pkg::FCA_BLK_W-1:0] cfg_wdata_i
);

  fca_pkg::fca_cmd_t  cmd;
  fca_pkg::fca_stat_t stat;

  fca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fca_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

### rtl/fca_checker.sv
module fca_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fca_pkg::fca_out_t out_item_o
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

  // One item at a time: no acceptance in the cycle after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in progress");

  // A new result is issued only from the busy side, never from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in progress");

  // A failed allocation reports block zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == fca_pkg::ST_NO_FREE
      |-> out_item_o.result_block == '0)
    else $error("no-free status with a non-zero block");

endmodule

bind fat_chain_allocator_core fca_checker u_fca_checker (.*);
